### rtl/gn2_pkg.sv
package gn2_pkg;

   // Default fraction width of the coordinates and lattice size
   localparam int FRACTION_BITS_DEF = 16;
   localparam int LATTICE_SIZE      = 256;

   // Output format, Q2.16
   localparam int OUT_W = 18;

   // Rescale constants: r = floor((P + HALF_DEN + OFS) / 2966) - 2^18
   localparam int RESCALE_DEN   = 2966;
   localparam int RESCALE_OFS_Q = 18;
   localparam logic [31:0] RESCALE_ADD = 32'd777520587;   // 1483 + 2966 * 2^18
   localparam logic [31:0] RESCALE_K   = 32'd2965641613;  // ceil(2^43 / 2966)
   localparam int RESCALE_SH    = 43;

   typedef logic [7:0] perm_rom_type [LATTICE_SIZE];

   localparam perm_rom_type PERM_ROM = '{
      8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
      8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
      8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
      8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
      8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
      8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
      8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
      8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
      8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
      8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
      8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
      8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
      8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
      8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
      8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
      8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
      8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
      8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
      8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
      8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
      8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
      8'd215,8'd61,8'd156,8'd180
   };

   function automatic logic [7:0] perm(input logic [7:0] idx);
      return PERM_ROM[idx];
   endfunction

endpackage

### rtl/gradient_noise_2d.sv
// Channel | Dir | Words                          | Handshake
// req     | in  | req_coord_x, req_coord_y (Q.F)  | req_valid / req_stall
// rsp     | out | rsp_noise_value (Q2.16)         | rsp_valid / rsp_stall
//
// One word per cycle in, one word per cycle out, unless a waiting result is stalled.
// The pipeline has eleven stages, every stage one register deep.
// Reset (synchronous, active high) clears the valid bits only.
// A stall on rsp while a result waits freezes the whole pipeline; req_stall follows rsp_stall when a
// result is waiting, so no word is lost or repeated.
module gradient_noise_2d
   import gn2_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [31:0]      req_coord_x,
   input  logic signed [31:0]      req_coord_y,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [OUT_W-1:0] rsp_noise_value
);
   localparam int F   = FRACTION_BITS;
   localparam int GW  = F + 3;
   localparam int DW  = F + 4;
   localparam int RW  = F + 4;
   localparam int XW  = F + 16;
   localparam int SW  = XW + 17;
   localparam int NST = 11;

   logic           adv;
   logic [NST:1]   vld_ff, vld_in;

   // stage 1
   logic [31:0]    mx, my;
   logic [7:0]     cx_ff, cy_ff;
   logic [F-1:0]   fx1_ff, fy1_ff;
   // stage 2
   logic [7:0]     a_ff, b_ff;
   logic [F-1:0]   fx2_ff, fy2_ff;
   // stage 3
   logic [7:0]     aa_ff, ab_ff, ba_ff, bb_ff;
   logic [F-1:0]   fx3_ff, fy3_ff;
   // stage 4
   logic [7:0]     paa, pab, pba, pbb;
   logic [3:0]     h00_ff, h01_ff, h10_ff, h11_ff;
   logic [F-1:0]   fx4_ff, fy4_ff;
   logic [F-1:0]   wu4, wv4;
   // stage 5
   logic signed [GW-1:0] g00_ff, g10_ff, g01_ff, g11_ff;
   logic [F-1:0]   wu5_ff, wv5_ff;
   // stage 6
   logic signed [2*F+4:0] p0_ff, p1_ff;
   logic signed [GW-1:0]  g00_6_ff, g01_6_ff;
   logic [F-1:0]   wv6_ff;
   // stage 7
   logic signed [RW-1:0]  row0_ff, row1_ff;
   logic [F-1:0]   wv7_ff;
   // stage 8
   logic signed [2*F+5:0] pn_ff;
   logic signed [RW-1:0]  row0_8_ff;
   // stage 9
   logic signed [RW:0]    n_val;
   logic signed [XW-1:0]  x_val;
   logic signed [SW-1:0]  xs;
   logic [31:0]           p_sum;
   logic [30:0]           p_ff;
   // stage 10
   logic [62:0]           q_ff;
   // stage 11
   logic signed [20:0]    r_val;
   logic signed [OUT_W-1:0] out_in, out_ff;

   function automatic logic signed [GW-1:0] grad(input logic [3:0] h,
         input logic signed [F:0] x, input logic signed [F:0] y);
      logic signed [GW-1:0] u, v;
      u = (h < 4'd8) ? GW'(x) : GW'(y);
      if (h < 4'd4)
         v = GW'(y);
      else if (h == 4'd12 || h == 4'd14)
         v = GW'(x);
      else
         v = '0;
      if (h[0]) u = -u;
      if (h[1]) v = -v;
      return u + v;
   endfunction

   // whole pipeline moves unless a result waits on a stalled consumer
   assign adv       = !(vld_ff[NST] && rsp_stall);
   assign req_stall = vld_ff[NST] && rsp_stall;
   assign vld_in    = {vld_ff[NST-1:1], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // magnitudes; the most negative value maps to 2^31
   assign mx = req_coord_x[31] ? (~req_coord_x + 32'd1) : req_coord_x;
   assign my = req_coord_y[31] ? (~req_coord_y + 32'd1) : req_coord_y;

   // fade curves, stages 2 to 4
   gn2_fade #(.FRACTION_BITS(F)) u_fade_x (
      .clock(clock), .adv(adv), .frac(fx1_ff), .weight(wu4));
   gn2_fade #(.FRACTION_BITS(F)) u_fade_y (
      .clock(clock), .adv(adv), .frac(fy1_ff), .weight(wv4));

   // corner hash lookups
   assign paa = perm(aa_ff);
   assign pab = perm(ab_ff);
   assign pba = perm(ba_ff);
   assign pbb = perm(bb_ff);

   // rescale numerator
   always_comb begin
      n_val = RW'(row0_8_ff) + (RW+1)'(pn_ff >>> F);
      x_val = XW'(n_val) * XW'(11'sd1000) + $signed(XW'({10'd690, {F{1'b0}}}));
      xs    = $signed({x_val, 17'b0}) >>> F;
      p_sum = 32'(xs) + RESCALE_ADD;
   end

   // quotient and clamp
   always_comb begin
      r_val = $signed({1'b0, q_ff[62:RESCALE_SH]}) - $signed(21'(1 << RESCALE_OFS_Q));
      if (r_val < -21'sd131072)
         out_in = {1'b1, {(OUT_W-1){1'b0}}};
      else if (r_val > 21'sd131071)
         out_in = {1'b0, {(OUT_W-1){1'b1}}};
      else
         out_in = OUT_W'(r_val);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // 1: split
         cx_ff  <= mx[F+7:F];
         cy_ff  <= my[F+7:F];
         fx1_ff <= mx[F-1:0];
         fy1_ff <= my[F-1:0];
         // 2: first hash
         a_ff   <= perm(cx_ff) + cy_ff;
         b_ff   <= perm(cx_ff + 8'd1) + cy_ff;
         fx2_ff <= fx1_ff;
         fy2_ff <= fy1_ff;
         // 3: second hash
         aa_ff  <= perm(a_ff);
         ab_ff  <= perm(a_ff + 8'd1);
         ba_ff  <= perm(b_ff);
         bb_ff  <= perm(b_ff + 8'd1);
         fx3_ff <= fx2_ff;
         fy3_ff <= fy2_ff;
         // 4: corner hashes
         h00_ff <= paa[3:0];
         h01_ff <= pab[3:0];
         h10_ff <= pba[3:0];
         h11_ff <= pbb[3:0];
         fx4_ff <= fx3_ff;
         fy4_ff <= fy3_ff;
         // 5: gradients
         g00_ff <= grad(h00_ff, $signed({1'b0, fx4_ff}), $signed({1'b0, fy4_ff}));
         g10_ff <= grad(h10_ff, $signed({1'b1, fx4_ff}), $signed({1'b0, fy4_ff}));
         g01_ff <= grad(h01_ff, $signed({1'b0, fx4_ff}), $signed({1'b1, fy4_ff}));
         g11_ff <= grad(h11_ff, $signed({1'b1, fx4_ff}), $signed({1'b1, fy4_ff}));
         wu5_ff <= wu4;
         wv5_ff <= wv4;
         // 6: x blend products
         p0_ff    <= $signed({1'b0, wu5_ff}) * (DW'(g10_ff) - DW'(g00_ff));
         p1_ff    <= $signed({1'b0, wu5_ff}) * (DW'(g11_ff) - DW'(g01_ff));
         g00_6_ff <= g00_ff;
         g01_6_ff <= g01_ff;
         wv6_ff   <= wv5_ff;
         // 7: x blend sums
         row0_ff <= RW'(g00_6_ff) + RW'(p0_ff >>> F);
         row1_ff <= RW'(g01_6_ff) + RW'(p1_ff >>> F);
         wv7_ff  <= wv6_ff;
         // 8: y blend product
         pn_ff     <= $signed({1'b0, wv7_ff}) * ((RW+1)'(row1_ff) - (RW+1)'(row0_ff));
         row0_8_ff <= row0_ff;
         // 9: shifted numerator
         p_ff <= p_sum[30:0];
         // 10: reciprocal product
         q_ff <= 63'(p_ff) * 63'(RESCALE_K);
         // 11: result word
         out_ff <= out_in;
      end
   end

   assign rsp_valid       = vld_ff[NST];
   assign rsp_noise_value = out_ff;

endmodule

### rtl/gn2_fade.sv
module gn2_fade
   import gn2_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     adv,
   input  logic [FRACTION_BITS-1:0] frac,
   output logic [FRACTION_BITS-1:0] weight
);
   localparam int F = FRACTION_BITS;

   logic [F-1:0]   f_ff, f_in;
   logic [2*F-1:0] sq_ff, sq_in;
   logic [F-1:0]   t3_ff, t3_in;
   logic [F+3:0]   q_ff, q_in;
   logic [F-1:0]   w_ff, w_in;
   logic [2*F+4:0] poly;
   logic [2*F-1:0] cube;
   logic [2*F+3:0] prod;

   // stage a: square
   assign f_in  = frac;
   assign sq_in = frac * frac;

   // stage b: t^3 and 6t^2 - 15t + 10
   always_comb begin
      poly  = (2*F+5)'(sq_ff) * (2*F+5)'(6) + (2*F+5)'({4'd10, {(2*F){1'b0}}})
            - (2*F+5)'({f_ff, {F{1'b0}}}) * (2*F+5)'(15);
      q_in  = poly[2*F+3:F];
      cube  = sq_ff[2*F-1:F] * f_ff;
      t3_in = cube[2*F-1:F];
   end

   // stage c: weight, always below one
   assign prod = t3_ff * q_ff;
   assign w_in = prod[2*F-1:F];

   always_ff @(posedge clock) begin
      if (adv) begin
         f_ff  <= f_in;
         sq_ff <= sq_in;
         t3_ff <= t3_in;
         q_ff  <= q_in;
         w_ff  <= w_in;
      end
   end

   assign weight = w_ff;

endmodule

### rtl/gn2_check.sv
module gn2_check
   import gn2_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic signed [OUT_W-1:0] rsp_noise_value
);

   // input only stalls behind a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a stalled result");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word after reset");

   // stalled result stays offered
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result word dropped under stall");

   // stalled result keeps its value
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_noise_value))
      else $error("result word changed under stall");

endmodule

bind gradient_noise_2d gn2_check u_gn2_check (
   .clock(clock),
   .reset(reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_noise_value(rsp_noise_value)
);

### dv/noise_checker.sv
`timescale 1ns / 100ps

// Watches both channels of gradient_noise_2d, predicts each noise word and
// compares it with what comes out.
module noise_checker
   import gn2_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic signed [31:0]      req_coord_x,
   input  logic signed [31:0]      req_coord_y,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic signed [OUT_W-1:0] rsp_noise_value,
   output int                      fail_count,
   output int                      pending
);

   localparam int FB = FRACTION_BITS_DEF;

   logic signed [OUT_W-1:0] noise_queue[$];

   function automatic longint unsigned coord_mag(logic [31:0] raw);
      logic [31:0] m;
      m = raw[31] ? (~raw + 32'd1) : raw;
      return longint'(m);
   endfunction

   function automatic longint fade_weight(longint unsigned f);
      longint unsigned q, t2, t3;
      q  = (6 * f * f + (longint'(10) << (2 * FB)) - 15 * (f << FB)) >> FB;
      t2 = (f * f) >> FB;
      t3 = (t2 * f) >> FB;
      return longint'((t3 * q) >> FB);
   endfunction

   function automatic longint floor_quot(longint n, longint d);
      if (n >= 0) return n / d;
      return -((-n + d - 1) / d);
   endfunction

   function automatic longint corner_grad(logic [7:0] hash, longint x, longint y);
      logic [3:0] h;
      longint u, v;
      h = hash[3:0];
      u = (h < 8) ? x : y;
      v = (h < 4) ? y : ((h == 12 || h == 14) ? x : 0);
      return (h[0] ? -u : u) + (h[1] ? -v : v);
   endfunction

   function automatic longint blend(longint w, longint a, longint b);
      return a + floor_quot(w * (b - a), longint'(1) << FB);
   endfunction

   function automatic logic [7:0] lattice(int idx);
      return PERM_ROM[idx & 255];
   endfunction

   function automatic logic signed [OUT_W-1:0] predict_noise(logic [31:0] x,
                                                             logic [31:0] y);
      longint unsigned mx, my;
      longint fx, fy, wu, wv, one, row0, row1, n, den, num, r;
      int cx, cy, a, b, aa, ab, ba, bb;
      one = longint'(1) << FB;
      mx = coord_mag(x);
      my = coord_mag(y);
      cx = int'((mx >> FB) & 255);
      cy = int'((my >> FB) & 255);
      fx = longint'(mx & (one - 1));
      fy = longint'(my & (one - 1));
      wu = fade_weight(fx);
      wv = fade_weight(fy);
      a  = lattice(cx) + cy;
      b  = lattice(cx + 1) + cy;
      aa = lattice(a);
      ab = lattice(a + 1);
      ba = lattice(b);
      bb = lattice(b + 1);
      row0 = blend(wu, corner_grad(lattice(aa), fx, fy),
                   corner_grad(lattice(ba), fx - one, fy));
      row1 = blend(wu, corner_grad(lattice(ab), fx, fy - one),
                   corner_grad(lattice(bb), fx - one, fy - one));
      n   = blend(wv, row0, row1);
      den = longint'(1483) << FB;
      num = (1000 * n + (longint'(690) << FB)) * (longint'(1) << 16);
      r   = floor_quot(2 * num + den, 2 * den);
      if (r < -131072) r = -131072;
      if (r > 131071) r = 131071;
      return r[OUT_W-1:0];
   endfunction

   assign pending = noise_queue.size();

   // Predict on accepted requests, compare on accepted responses
   always @(posedge clock) begin
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall)
            noise_queue.push_back(predict_noise(req_coord_x, req_coord_y));
         if (rsp_valid && !rsp_stall) begin
            if (noise_queue.size() == 0) begin
               $error("noise_value: unexpected word %0d", rsp_noise_value);
               fail_count <= fail_count + 1;
            end else if (noise_queue[0] !== rsp_noise_value) begin
               $error("noise_value: expected %0d, actual %0d",
                      noise_queue[0], rsp_noise_value);
               fail_count <= fail_count + 1;
               void'(noise_queue.pop_front());
            end else begin
               void'(noise_queue.pop_front());
            end
         end
      end
   end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;
   import gn2_pkg::*;

   localparam int  RAND_WORDS  = 1000;
   localparam int  CYCLE_LIMIT = 200000;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic signed [31:0]      req_coord_x;
   logic signed [31:0]      req_coord_y;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [OUT_W-1:0] rsp_noise_value;
   int                      fail_count;
   int                      pending;
   int                      cycle_count = 0;
   logic [63:0]             point_queue[$];
   bit                      stall_mode = 1'b0;

   gradient_noise_2d u_dut (.*);

   noise_checker u_chk (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Response stall: alternates between quiet stretches and random stalling
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_mode = ~stall_mode;
         rsp_stall <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b0;
      end
   end

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return {1'b1, 31'($urandom_range(0, 3))};
         1: return {16'($urandom_range(254, 257)), 16'($urandom)};
         2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
         3: return {16'($urandom), $urandom_range(0, 1) ? 16'hFFFF : 16'h0000};
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [31:0] edge_vals[8];
      int gap, burst;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_coord_x = '0;
      req_coord_y = '0;

      // Directed points: zero, exact integers, extremes, most negative value
      edge_vals = '{32'h0, 32'h0001_0000, 32'h0000_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'hFFFF_FFFF, 32'h00FF_8000, 32'h8000_0001};
      foreach (edge_vals[i])
         foreach (edge_vals[j])
            if ((i + j) % 3 == 0) point_queue.push_back({edge_vals[i], edge_vals[j]});
      for (int k = 0; k < RAND_WORDS; k++)
         point_queue.push_back({rand_coord(), rand_coord()});

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Bursts of words, each followed by a random gap or by none
      while (point_queue.size() > 0) begin
         burst = $urandom_range(1, 20);
         while (burst > 0 && point_queue.size() > 0) begin
            req_valid <= 1'b1;
            {req_coord_x, req_coord_y} <= point_queue.pop_front();
            @(posedge clock);
            while (req_stall) @(posedge clock);
            burst--;
         end
         gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;

      while (pending > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
